### rtl/core/ipv6p_pkg.sv
package ipv6p_pkg;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [4:0] HexNone = 5'd16;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_LEAD    = 3'd1,
    PH_TOP_OK  = 3'd2,
    PH_TOP_SEP = 3'd3,
    PH_GROUP   = 3'd4,
    PH_V4_DOT  = 3'd5,
    PH_V4_NUM  = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       empty_body;
  } req_t;

  typedef struct packed {
    logic        valid_res;
    logic [63:0] address_high;
    logic [63:0] address_low;
  } res_t;

  typedef struct packed {
    logic [7:0][15:0] pieces;
    logic [3:0]       piece_count;
    logic [3:0]       compress_at;
    logic             compress_seen;
    phase_e           parse_phase;
    logic [15:0]      group_hex_value;
    logic [2:0]       group_length;
    logic [8:0]       group_decimal_value;
    logic             group_all_decimal;
    logic [2:0]       dotted_parts_seen;
    logic             failed;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    pieces:              '0,
    piece_count:         4'd0,
    compress_at:         4'd0,
    compress_seen:       1'b0,
    parse_phase:         PH_START,
    group_hex_value:     16'd0,
    group_length:        3'd0,
    group_decimal_value: 9'd0,
    group_all_decimal:   1'b1,
    dotted_parts_seen:   3'd0,
    failed:              1'b0
  };

  function automatic logic is_dec(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [4:0] hex_of(logic [7:0] c);
    logic [4:0] h;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      h = {1'b0, c[3:0]};
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      h = {1'b0, 4'(c[3:0] + 4'd9)};
    end else begin
      h = HexNone;
    end
    return h;
  endfunction

endpackage

### rtl/core/ipv6p_step.sv
module ipv6p_step (
  input  ipv6p_pkg::parse_state_t state_i,
  input  ipv6p_pkg::req_t         req_i,
  output ipv6p_pkg::parse_state_t state_o,
  output logic                    ends_o,
  output ipv6p_pkg::res_t         res_o
);

  // ten times the group's decimal value plus the new digit
  function automatic logic [11:0] dec_next(logic [8:0] v, logic [7:0] c);
    return 12'(12'(v) * 12'd10 + 12'(c[3:0]));
  endfunction

  function automatic ipv6p_pkg::parse_state_t store_group(ipv6p_pkg::parse_state_t s);
    ipv6p_pkg::parse_state_t r;
    r = s;
    r.pieces[s.piece_count[2:0]] = s.group_hex_value;
    if (s.piece_count < 4'd8) begin
      r.piece_count = s.piece_count + 4'd1;
    end
    return r;
  endfunction

  function automatic ipv6p_pkg::parse_state_t finish_v4(ipv6p_pkg::parse_state_t s);
    ipv6p_pkg::parse_state_t r;
    logic [2:0]              idx;
    r   = s;
    idx = s.piece_count[2:0];
    r.pieces[idx] = 16'({s.pieces[idx][7:0], 8'h00} + 16'(s.group_decimal_value));
    r.dotted_parts_seen = s.dotted_parts_seen + 3'd1;
    if (((r.dotted_parts_seen == 3'd2) || (r.dotted_parts_seen == 3'd4))
        && (s.piece_count < 4'd8)) begin
      r.piece_count = s.piece_count + 4'd1;
    end
    return r;
  endfunction

  function automatic ipv6p_pkg::parse_state_t loop_top(ipv6p_pkg::parse_state_t s,
                                                       logic [7:0] c);
    ipv6p_pkg::parse_state_t r;
    logic [4:0]              h;
    r = s;
    h = ipv6p_pkg::hex_of(c);
    if (s.piece_count >= 4'd8) begin
      r.failed = 1'b1;
    end else if (c == ipv6p_pkg::ChColon) begin
      if (s.compress_seen) begin
        r.failed = 1'b1;
      end else begin
        r.piece_count   = s.piece_count + 4'd1;
        r.compress_at   = s.piece_count + 4'd1;
        r.compress_seen = 1'b1;
        r.parse_phase   = ipv6p_pkg::PH_TOP_OK;
      end
    end else if (h == ipv6p_pkg::HexNone) begin
      r.failed = 1'b1;
    end else begin
      r.group_hex_value = {12'd0, h[3:0]};
      r.group_length    = 3'd1;
      if (ipv6p_pkg::is_dec(c)) begin
        r.group_decimal_value = {5'd0, c[3:0]};
        r.group_all_decimal   = 1'b1;
      end else begin
        r.group_decimal_value = 9'd0;
        r.group_all_decimal   = 1'b0;
      end
      r.parse_phase = ipv6p_pkg::PH_GROUP;
    end
    return r;
  endfunction

  function automatic ipv6p_pkg::parse_state_t in_group(ipv6p_pkg::parse_state_t s,
                                                       logic [7:0] c);
    ipv6p_pkg::parse_state_t r;
    logic [4:0]              h;
    logic [11:0]             n;
    r = s;
    h = ipv6p_pkg::hex_of(c);
    n = dec_next(s.group_decimal_value, c);
    if (h != ipv6p_pkg::HexNone) begin
      if (s.group_length >= 3'd4) begin
        r.failed = 1'b1;
      end else begin
        r.group_hex_value = {s.group_hex_value[11:0], h[3:0]};
        r.group_length    = s.group_length + 3'd1;
        if (s.group_all_decimal) begin
          if (!ipv6p_pkg::is_dec(c) || (s.group_decimal_value == 9'd0) || (n > 12'd255)) begin
            r.group_all_decimal = 1'b0;
          end else begin
            r.group_decimal_value = n[8:0];
          end
        end
      end
    end else if (c == ipv6p_pkg::ChColon) begin
      r = store_group(s);
      r.parse_phase = ipv6p_pkg::PH_TOP_SEP;
    end else if (c == ipv6p_pkg::ChDot) begin
      if (!s.group_all_decimal || (s.piece_count > 4'd6)) begin
        r.failed = 1'b1;
      end else begin
        r.dotted_parts_seen = 3'd0;
        r = finish_v4(r);
        r.parse_phase = ipv6p_pkg::PH_V4_DOT;
      end
    end else begin
      r.failed = 1'b1;
    end
    return r;
  endfunction

  function automatic ipv6p_pkg::parse_state_t take_char(ipv6p_pkg::parse_state_t s,
                                                        logic [7:0] c);
    ipv6p_pkg::parse_state_t r;
    logic [11:0]             n;
    r = s;
    n = dec_next(s.group_decimal_value, c);
    unique case (s.parse_phase)
      ipv6p_pkg::PH_START: begin
        if (c == ipv6p_pkg::ChColon) begin
          r.parse_phase = ipv6p_pkg::PH_LEAD;
        end else begin
          r = loop_top(s, c);
        end
      end
      ipv6p_pkg::PH_LEAD: begin
        if (c != ipv6p_pkg::ChColon) begin
          r.failed = 1'b1;
        end else begin
          r.piece_count   = 4'd1;
          r.compress_at   = 4'd1;
          r.compress_seen = 1'b1;
          r.parse_phase   = ipv6p_pkg::PH_TOP_OK;
        end
      end
      ipv6p_pkg::PH_TOP_OK, ipv6p_pkg::PH_TOP_SEP: begin
        r = loop_top(s, c);
      end
      ipv6p_pkg::PH_GROUP: begin
        r = in_group(s, c);
      end
      ipv6p_pkg::PH_V4_DOT: begin
        if (!ipv6p_pkg::is_dec(c)) begin
          r.failed = 1'b1;
        end else begin
          r.group_decimal_value = {5'd0, c[3:0]};
          r.parse_phase         = ipv6p_pkg::PH_V4_NUM;
        end
      end
      ipv6p_pkg::PH_V4_NUM: begin
        if (ipv6p_pkg::is_dec(c)) begin
          if ((s.group_decimal_value == 9'd0) || (n > 12'd255)) begin
            r.failed = 1'b1;
          end else begin
            r.group_decimal_value = n[8:0];
          end
        end else if (c == ipv6p_pkg::ChDot) begin
          r = finish_v4(s);
          if (r.dotted_parts_seen >= 3'd4) begin
            r.failed = 1'b1;
          end else begin
            r.parse_phase = ipv6p_pkg::PH_V4_DOT;
          end
        end else begin
          r.failed = 1'b1;
        end
      end
      default: begin
        r.failed = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic ipv6p_pkg::parse_state_t take_end(ipv6p_pkg::parse_state_t s);
    ipv6p_pkg::parse_state_t r;
    logic [7:0][15:0]        tmp;
    logic [3:0]              moved;
    r     = s;
    tmp   = '0;
    moved = 4'd0;
    if (!r.failed) begin
      unique case (r.parse_phase)
        ipv6p_pkg::PH_TOP_OK: begin
          r.failed = 1'b0;
        end
        ipv6p_pkg::PH_GROUP: begin
          r = store_group(r);
        end
        ipv6p_pkg::PH_V4_NUM: begin
          r = finish_v4(r);
          if (r.dotted_parts_seen != 3'd4) begin
            r.failed = 1'b1;
          end
        end
        default: begin
          r.failed = 1'b1;
        end
      endcase
    end
    if (!r.failed) begin
      if (r.compress_seen) begin
        if ((r.compress_at > r.piece_count) || (r.piece_count > 4'd8)) begin
          r.failed = 1'b1;
        end else begin
          // pieces after the gap move to the tail, zeros fill the gap
          moved = r.piece_count - r.compress_at;
          for (int k = 0; k < 8; k++) begin
            if (4'(k) < r.compress_at) begin
              tmp[k] = r.pieces[k];
            end else if ((moved != 4'd0) && (4'(k) >= 4'd8 - moved)) begin
              tmp[k] = r.pieces[3'(4'(k) + r.piece_count)];
            end
          end
          r.pieces = tmp;
        end
      end else if (r.piece_count != 4'd8) begin
        r.failed = 1'b1;
      end
    end
    return r;
  endfunction

  ipv6p_pkg::parse_state_t after_char;
  ipv6p_pkg::parse_state_t after_end;

  always_comb begin
    after_char = state_i;
    if (!req_i.empty_body && !state_i.failed) begin
      after_char = take_char(state_i, req_i.char_code);
    end
    after_end = take_end(after_char);
  end

  assign ends_o  = req_i.empty_body || req_i.last_char;
  assign state_o = ends_o ? ipv6p_pkg::StateReset : after_char;

  always_comb begin
    res_o.valid_res    = !after_end.failed;
    res_o.address_high = '0;
    res_o.address_low  = '0;
    if (!after_end.failed) begin
      res_o.address_high = {after_end.pieces[0], after_end.pieces[1],
                            after_end.pieces[2], after_end.pieces[3]};
      res_o.address_low  = {after_end.pieces[4], after_end.pieces[5],
                            after_end.pieces[6], after_end.pieces[7]};
    end
  end

endmodule

### rtl/core/ipv6_address_parser_top.sv
// channel   direction  handshake                 payload
// request   in         req_valid_i / req_ready_o req_i (ipv6p_pkg::req_t)
// result    out        res_valid_o / res_ready_i res_o (ipv6p_pkg::res_t)
//
// one request per cycle sustained; a request is held in the input register,
// its character is parsed and any result is registered in the result register
// only a request that ends the text waits on a full, stalled result register;
// other requests keep flowing while a result waits to be taken
// reset clears the parse state and both valid flags, the parser is ready at once
module ipv6_address_parser_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  ipv6p_pkg::req_t   req_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output ipv6p_pkg::res_t   res_o
);

  ipv6p_pkg::req_t         req_q;
  logic                    req_vld_q;
  ipv6p_pkg::res_t         res_q;
  ipv6p_pkg::res_t         res_d;
  logic                    res_vld_q;
  ipv6p_pkg::parse_state_t state_q;
  ipv6p_pkg::parse_state_t state_d;
  logic                    ends;
  logic                    adv;

  ipv6p_step u_step (
    .state_i (state_q),
    .req_i   (req_q),
    .state_o (state_d),
    .ends_o  (ends),
    .res_o   (res_d)
  );

  // the held request moves on unless it ends the text and the result slot is blocked
  assign adv         = req_vld_q && (!ends || !res_vld_q || res_ready_i);
  assign req_ready_o = !req_vld_q || adv;
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
      state_q   <= ipv6p_pkg::StateReset;
    end else begin
      if (req_ready_o) begin
        req_vld_q <= req_valid_i;
      end
      if (adv) begin
        state_q <= state_d;
      end
      if (adv && ends) begin
        res_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
    end
    if (adv && ends) begin
      res_q <= res_d;
    end
  end

endmodule
